// ===== rtl/sitd_pkg.sv =====
// shared types and constants for the signed integer to decimal text block
package sitd_pkg;

    localparam int VALUE_PORT_W = 64;
    localparam int CHAR_W       = 8;
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ADD_TERM  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TERM_CHAR = 8'd1;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] TERM_RESET = 8'h0A;

    // handoff from the converter to the character emitter
    typedef struct packed {
        logic done;
        logic neg;
    } sitd_ctl_t;

endpackage

// ===== rtl/sitd_if.sv =====
// stream interfaces: input value, output characters, configuration writes
interface sitd_value_if import sitd_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [VALUE_PORT_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface sitd_text_if import sitd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              last;

    modport source (output valid, output text_char, output last, input ready);
    modport sink (input valid, input text_char, input last, output ready);
endinterface

interface sitd_cfg_if import sitd_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sitd_b2b.sv =====
// bit-serial binary to bcd converter (shift and add 3), one input bit per cycle
module sitd_b2b import sitd_pkg::*; #(
    parameter int VALUE_WIDTH = 64,
    parameter int NUM_DIGITS  = 19
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [VALUE_WIDTH-1:0]  value,
    input  logic                    take,
    output logic                    idle,
    output sitd_ctl_t               ctl,
    output logic [NUM_DIGITS*4-1:0] bcd
);

    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
    localparam int BCD_W = NUM_DIGITS * 4;

    logic                   busy_reg;
    logic                   done_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [VALUE_WIDTH-1:0] shift_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BCD_W-1:0]       bcd_adj;
    logic [BCD_W-1:0]       bcd_next;
    logic                   neg_reg;
    logic                   neg_in;
    logic [VALUE_WIDTH-1:0] mag_in;

    // magnitude at full width: the most negative value maps to 2^(w-1)
    assign neg_in = value[VALUE_WIDTH-1];
    assign mag_in = neg_in ? (~value + 1'b1) : value;

    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                (bcd_reg[4*i +: 4] + 4'd3) : bcd_reg[4*i +: 4];
        end
        bcd_next = {bcd_adj[BCD_W-2:0], shift_reg[VALUE_WIDTH-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(VALUE_WIDTH);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else if (take)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= mag_in;
            bcd_reg   <= '0;
            neg_reg   <= neg_in;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            bcd_reg   <= bcd_next;
        end
    end

    assign idle     = !busy_reg && !done_reg;
    assign ctl.done = done_reg;
    assign ctl.neg  = neg_reg;
    assign bcd      = bcd_reg;

endmodule

// ===== rtl/sitd_emit.sv =====
// character emitter: sign, digits without leading zeros, optional terminator
module sitd_emit import sitd_pkg::*; #(
    parameter int NUM_DIGITS = 19
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sitd_ctl_t               ctl,
    input  logic [NUM_DIGITS*4-1:0] bcd_in,
    input  logic                    add_term,
    input  logic [CHAR_W-1:0]       term_char,
    output logic                    take,
    output logic                    out_valid,
    output logic [CHAR_W-1:0]       out_char,
    output logic                    out_last,
    input  logic                    out_ready
);

    localparam int BCD_W  = NUM_DIGITS * 4;
    localparam int DCNT_W = $clog2(NUM_DIGITS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SIGN = 2'd1;
    localparam logic [1:0] ST_DIG  = 2'd2;
    localparam logic [1:0] ST_TERM = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [DCNT_W-1:0] dcnt_reg, dcnt_next;
    logic              started_reg, started_next;
    logic              ovalid_reg, ovalid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;
    logic [3:0]        top_dig;
    logic              slot;
    logic              final_dig;

    assign top_dig   = bcd_reg[BCD_W-1 -: 4];
    assign slot      = !ovalid_reg || out_ready;
    assign final_dig = (dcnt_reg == DCNT_W'(1));

    always_comb
    begin
        state_next   = state_reg;
        bcd_next     = bcd_reg;
        dcnt_next    = dcnt_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        take         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.done)
                begin
                    take         = 1'b1;
                    bcd_next     = bcd_in;
                    dcnt_next    = DCNT_W'(NUM_DIGITS);
                    started_next = 1'b0;
                    state_next   = ctl.neg ? ST_SIGN : ST_DIG;
                end
            end
            ST_SIGN:
            begin
                if (slot)
                begin
                    ovalid_next = 1'b1;
                    char_next   = CHAR_MINUS;
                    last_next   = 1'b0;
                    state_next  = ST_DIG;
                end
            end
            ST_DIG:
            begin
                // leading zeros are dropped without a transfer, the units digit never
                if (top_dig == 4'd0 && !started_reg && !final_dig)
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next = dcnt_reg - 1'b1;
                end
                else if (slot)
                begin
                    ovalid_next  = 1'b1;
                    char_next    = CHAR_ZERO + {4'd0, top_dig};
                    last_next    = final_dig && !add_term;
                    bcd_next     = {bcd_reg[BCD_W-5:0], 4'd0};
                    dcnt_next    = dcnt_reg - 1'b1;
                    started_next = 1'b1;
                    if (final_dig)
                    begin
                        state_next = add_term ? ST_TERM : ST_IDLE;
                    end
                end
            end
            ST_TERM:
            begin
                if (slot)
                begin
                    ovalid_next = 1'b1;
                    char_next   = term_char;
                    last_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            ovalid_reg  <= 1'b0;
            started_reg <= 1'b0;
            dcnt_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ovalid_reg  <= ovalid_next;
            started_reg <= started_next;
            dcnt_reg    <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = ovalid_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

// ===== rtl/signed_int_to_decimal_text_top.sv =====
// signed integer to decimal ascii text converter, top level
//
// value_ch carries one signed integer per transfer; only its low VALUE_WIDTH
// bits are used. text_ch returns its decimal text one character per transfer,
// '-' first for a negative value, no leading zeros, then the terminator when
// add_terminator is set; last marks the final character. cfg_ch writes
// register 0 (add_terminator) and 1 (terminator_char); it is always ready.
// After bit-serial bcd conversion and a handoff to the emitter, the sign of
// a negative value is sent, leading zeros are dropped, and the characters
// then leave one per cycle while the receiver is ready.
// The converter takes the next value in the cycle after it has handed its
// digits to the emitter, so a new value is taken at the pace of the converter
// (load, shifts, handoff) or of the emitter (zero skips plus characters),
// whichever is slower. A receiver stall holds the current character in the
// output register and stops the emitter; conversion of a waiting value
// continues. Reset clears both sides and sets add_terminator to 0 and
// terminator_char to newline.
module signed_int_to_decimal_text_top import sitd_pkg::*; #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic     clk,
    input  logic     rst_n,
    sitd_value_if.sink   value_ch,
    sitd_text_if.source  text_ch,
    sitd_cfg_if.sink     cfg_ch
);

    // digit count of 2^(VALUE_WIDTH-1): floor((w-1)*log10(2)) + 1
    localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

    logic                    add_term_reg;
    logic [CHAR_W-1:0]       term_char_reg;
    logic                    conv_idle;
    logic                    start;
    logic                    take;
    sitd_ctl_t               ctl;
    logic [NUM_DIGITS*4-1:0] bcd;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_term_reg  <= 1'b0;
            term_char_reg <= TERM_RESET;
        end
        else if (cfg_ch.valid)
        begin
            case (cfg_ch.index)
                REG_ADD_TERM:  add_term_reg  <= cfg_ch.data[0];
                REG_TERM_CHAR: term_char_reg <= cfg_ch.data[CHAR_W-1:0];
                default:       ;
            endcase
        end
    end

    assign value_ch.ready = conv_idle;
    assign start          = value_ch.valid && conv_idle;

    sitd_b2b #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_b2b (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .value (value_ch.value[VALUE_WIDTH-1:0]),
        .take  (take),
        .idle  (conv_idle),
        .ctl   (ctl),
        .bcd   (bcd)
    );

    sitd_emit #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .bcd_in    (bcd),
        .add_term  (add_term_reg),
        .term_char (term_char_reg),
        .take      (take),
        .out_valid (text_ch.valid),
        .out_char  (text_ch.text_char),
        .out_last  (text_ch.last),
        .out_ready (text_ch.ready)
    );

endmodule

// ===== rtl/sitd_checker.sv =====
// port-level checker for the decimal text converter, bound to the top level
module sitd_checker import sitd_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [CHAR_W-1:0] text_char,
    input logic              out_last,
    input logic              cfg_ready
);

    // a character offered but not taken stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    // every character before the last one is a sign or a digit
    a_body_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |->
            (text_char == CHAR_MINUS) ||
            (text_char >= CHAR_ZERO && text_char <= CHAR_ZERO + 8'd9))
        else $error("non-final character is not a sign or digit");

    // converter takes one value at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after a transfer");

    // register writes are never stalled
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind signed_int_to_decimal_text_top sitd_checker u_sitd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (value_ch.valid),
    .in_ready  (value_ch.ready),
    .out_valid (text_ch.valid),
    .out_ready (text_ch.ready),
    .text_char (text_ch.text_char),
    .out_last  (text_ch.last),
    .cfg_ready (cfg_ch.ready)
);

// ===== tb/tb_signed_int_to_decimal_text_top.sv =====
// testbench for the signed integer to decimal text block: scoreboard, drivers, checks
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_text_top;
    import sitd_pkg::*;

    localparam int VW          = 64;
    localparam int MAX_DIGITS  = 20;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VW);

    typedef struct packed {
        logic [CHAR_W-1:0] text_char;
        logic              last;
    } char_beat_t;

    class decimal_text_scoreboard;
        char_beat_t        pending_text[$];
        logic              add_term;
        logic [CHAR_W-1:0] term_char;
        int                errors;

        function new();
            add_term  = 1'b0;
            term_char = TERM_RESET;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_ADD_TERM)
                add_term = data[0];
            else if (idx == REG_TERM_CHAR)
                term_char = data[CHAR_W-1:0];
        endfunction

        function void push_char(logic [CHAR_W-1:0] ch);
            char_beat_t beat;
            beat.text_char = ch;
            beat.last      = 1'b0;
            pending_text.push_back(beat);
        endfunction

        // queue the text of one accepted value
        function void note_value(logic [63:0] value);
            logic [63:0] v;
            logic [63:0] mag;
            logic        neg;
            logic [3:0]  digits [MAX_DIGITS];
            int          nd;
            int          i;
            v   = value & VALUE_MASK;
            neg = v[VW-1];
            // magnitude of the most negative value is still exact at full width
            mag = neg ? ((~v + 64'd1) & VALUE_MASK) : v;
            nd  = 0;
            do
            begin
                digits[nd] = 4'(mag % 64'd10);
                nd++;
                mag = mag / 64'd10;
            end
            while (mag != 64'd0 && nd < MAX_DIGITS);
            if (neg)
                push_char(CHAR_MINUS);
            for (i = nd - 1; i >= 0; i--)
                push_char(CHAR_ZERO + CHAR_W'(digits[i]));
            if (add_term)
                push_char(term_char);
            pending_text[pending_text.size() - 1].last = 1'b1;
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic lst);
            char_beat_t want;
            if (pending_text.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected character %h last %b", ch, lst);
                return;
            end
            want = pending_text.pop_front();
            if (want.text_char !== ch || want.last !== lst)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected char %h last %b, got char %h last %b",
                             want.text_char, want.last, ch, lst);
            end
        endfunction

        function int pending();
            return pending_text.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic no_idle;
    int   cycle_count;
    decimal_text_scoreboard sb;

    sitd_value_if value_ch();
    sitd_text_if  text_ch();
    sitd_cfg_if   cfg_ch();

    signed_int_to_decimal_text_top #(.VALUE_WIDTH(VW)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .value_ch (value_ch),
        .text_ch  (text_ch),
        .cfg_ch   (cfg_ch)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_signed_int_to_decimal_text_top failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] r;
        logic [63:0] p;
        int          k;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: return r;
            1:
            begin
                p = 64'($urandom_range(0, 999));
                return $urandom_range(0, 1) ? -p : p;
            end
            2:
            begin
                // just around a power of ten, where the digit count changes
                p = 64'd1;
                k = $urandom_range(1, 18);
                repeat (k) p = p * 64'd10;
                p = p + 64'($urandom_range(0, 2)) - 64'd1;
                return $urandom_range(0, 1) ? -p : p;
            end
            3:
            begin
                p = r >> $urandom_range(0, 63);
                return $urandom_range(0, 1) ? -p : p;
            end
            4:
            begin
                if ($urandom_range(0, 1))
                    return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
                return 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            end
            default: return r;
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_value(input logic [63:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            value_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        value_ch.valid = 1'b1;
        value_ch.value = v;
        do @(posedge clk); while (!value_ch.ready);
        sb.note_value(v);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic wait_for_text();
        value_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_value(random_value());
        value_ch.valid = 1'b0;
    endtask

    // receiver stalls
    initial
    begin
        int n;
        text_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            n = pick_gap();
            if (n > 0)
            begin
                text_ch.ready = 1'b0;
                repeat (n) @(negedge clk);
            end
            text_ch.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && text_ch.valid && text_ch.ready)
            sb.check_char(text_ch.text_char, text_ch.last);
    end

    initial
    begin
        logic [63:0] directed_values [$];
        directed_values = '{
            64'd0, 64'd1, -64'sd1, 64'd9, -64'sd9, 64'd10, -64'sd10, 64'd99,
            64'd100, -64'sd100, 64'd12345, 64'd1000000000, 64'd4294967296,
            -64'sd4294967295, 64'd999999999999999999, 64'd1000000000000000000,
            -64'sd1000000000000000000, 64'h7FFF_FFFF_FFFF_FFFF,
            64'h7FFF_FFFF_FFFF_FFFE, 64'h8000_0000_0000_0000,
            64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555
        };
        sb             = new();
        cycle_count    = 0;
        no_idle        = 1'b0;
        rst_n          = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = '0;
        cfg_ch.data    = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: no terminator
        foreach (directed_values[i])
            send_value(directed_values[i]);
        wait_for_text();

        // newline form
        write_reg(REG_ADD_TERM, 8'h01);
        send_value(64'd0);
        send_value(64'h8000_0000_0000_0000);
        send_random(40);
        wait_for_text();

        // string form, terminator of zero
        write_reg(REG_TERM_CHAR, 8'h00);
        send_value(-64'sd7);
        send_value(64'h7FFF_FFFF_FFFF_FFFF);
        send_random(40);
        wait_for_text();

        // terminator set but disabled; data bits above bit 0 are dropped
        write_reg(REG_TERM_CHAR, 8'hFF);
        write_reg(REG_ADD_TERM, 8'hFE);
        no_idle = 1'b1;
        send_random(40);
        wait_for_text();
        no_idle = 1'b0;

        // writes to unknown indexes change nothing
        write_reg(8'd2, 8'h00);
        write_reg(8'hFF, 8'h01);
        write_reg(REG_ADD_TERM, 8'h03);
        send_value(64'h8000_0000_0000_0000);
        send_random(40);
        wait_for_text();

        write_reg(REG_TERM_CHAR, 8'h0A);
        send_random(40);
        wait_for_text();

        repeat (VW + 30) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_signed_int_to_decimal_text_top passed");
        else
            $display("tb_signed_int_to_decimal_text_top failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sitd_pkg.sv
rtl/sitd_if.sv
rtl/sitd_b2b.sv
rtl/sitd_emit.sv
rtl/signed_int_to_decimal_text_top.sv
rtl/sitd_checker.sv
tb/tb_signed_int_to_decimal_text_top.sv
